FILE: rtl/linear_counting_sketch_unit_assert.svh
// Assertion macros for the linear counting sketch unit.
// Used by linear_counting_sketch_unit.sv; needs no other file.
`ifndef LINEAR_COUNTING_SKETCH_UNIT_ASSERT_SVH
`define LINEAR_COUNTING_SKETCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define LCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("linear counting sketch: same-cycle check failed");

// Next-cycle implication, disabled while reset is applied.
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("linear counting sketch: next-cycle check failed");

`endif

FILE: rtl/lcs_pkg.sv
// Shared types, constants and the threshold table of the linear counting sketch.
// No dependencies; imported by every module of the block but lcs_ram.
`default_nettype none

package lcs_pkg;

    localparam int PREC_W        = 5;
    localparam int HASH_W        = 64;
    localparam int EST_W         = 22;
    localparam int UNSET_W       = 19;
    localparam int THR_W         = 19;
    localparam int PREC_MIN      = 4;
    localparam int PREC_RESET    = 14;
    localparam int ROW_LOG       = 3;
    localparam int ROW_W         = 1 << ROW_LOG;
    localparam int LOG_FRAC_BITS = 16;
    localparam int FRAC_CW       = $clog2(LOG_FRAC_BITS);
    localparam int MANT_FRAC     = 30;
    localparam int MANT_W        = MANT_FRAC + 1;
    localparam int LG_W          = PREC_W + LOG_FRAC_BITS;
    localparam int MUL_W         = 32;

    localparam logic [63:0] LN2_Q32 = 64'hB172_17F8;
    localparam logic [LOG_FRAC_BITS-1:0] LN2F =
        LOG_FRAC_BITS'(LN2_Q32 >> (32 - LOG_FRAC_BITS));
    localparam logic [PREC_W-1:0] K_START = PREC_W'(UNSET_W - 1);

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_ESTIMATE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [HASH_W-1:0] hash_value;
    } cmd_word_t;

    typedef struct packed {
        logic [EST_W-1:0]   estimate;
        logic               saturated;
        logic [UNSET_W-1:0] unset_bits;
        logic [THR_W-1:0]   threshold;
    } res_word_t;

    typedef struct packed {
        logic               start;
        logic [UNSET_W-1:0] unset;
        logic [PREC_W-1:0]  precision;
    } est_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [EST_W-1:0] estimate;
    } est_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_EST,
        ST_DONE
    } lcs_state_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_NORM,
        E_SQUARE,
        E_DIFF,
        E_SCALE,
        E_SHIFT
    } est_state_t;

    function automatic logic [THR_W-1:0] threshold_of(input logic [PREC_W-1:0] p);
        logic [THR_W-1:0] t;
        unique case (p)
            5'd4:    t = 19'd10;
            5'd5:    t = 19'd20;
            5'd6:    t = 19'd40;
            5'd7:    t = 19'd80;
            5'd8:    t = 19'd220;
            5'd9:    t = 19'd400;
            5'd10:   t = 19'd900;
            5'd11:   t = 19'd1800;
            5'd12:   t = 19'd3100;
            5'd13:   t = 19'd6500;
            5'd14:   t = 19'd11500;
            5'd15:   t = 19'd20000;
            5'd16:   t = 19'd50000;
            5'd17:   t = 19'd120000;
            5'd18:   t = 19'd350000;
            default: t = 19'd10;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/lcs_mul.sv
// Shared unsigned multiplier of the estimate datapath.
// Depends on lcs_pkg for the operand width.
`default_nettype none

module lcs_mul (
    input  logic [lcs_pkg::MUL_W-1:0]   a,
    input  logic [lcs_pkg::MUL_W-1:0]   b,
    output logic [2*lcs_pkg::MUL_W-1:0] product
);

    import lcs_pkg::*;

    assign product = {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};

endmodule

`default_nettype wire

FILE: rtl/lcs_est_unit.sv
// Estimate sequencer: normalise, log2 by repeated squaring, scale by ln 2 and m.
// Depends on lcs_pkg and lcs_mul.
`default_nettype none

module lcs_est_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcs_pkg::est_ctrl_t    ctrl,
    output lcs_pkg::est_stat_t    stat
);

    import lcs_pkg::*;

    est_state_t           state_reg, state_next;
    logic [MANT_W-1:0]    x_reg, x_next;
    logic [PREC_W-1:0]    k_reg, k_next;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [FRAC_CW-1:0]   cnt_reg, cnt_next;
    logic [LG_W-1:0]      l_reg, l_next;
    logic [LG_W-1:0]      lnv_reg, lnv_next;
    logic [EST_W-1:0]     est_reg, est_next;
    logic                 done_reg, done_next;

    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   product;
    logic [MANT_W:0]      sq;
    logic [LG_W-1:0]      lg, pf;
    logic [63:0]          scaled;

    lcs_mul u_mul (
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign sq     = product[MANT_FRAC +: MANT_W+1];
    assign lg     = {k_reg, frac_reg};
    assign pf     = {ctrl.precision, {LOG_FRAC_BITS{1'b0}}};
    assign scaled = ({{(64-LG_W){1'b0}}, lnv_reg} << ctrl.precision) >> LOG_FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        k_reg    <= k_next;
        frac_reg <= frac_next;
        l_reg    <= l_next;
        lnv_reg  <= lnv_next;
        est_reg  <= est_next;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        l_next     = l_reg;
        lnv_next   = lnv_reg;
        est_next   = est_reg;
        done_next  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (ctrl.start)
                begin
                    x_next     = {ctrl.unset, {(MANT_W-UNSET_W){1'b0}}};
                    k_next     = K_START;
                    state_next = E_NORM;
                end
            end
            E_NORM:
            begin
                // shift left until the leading one sits at the integer bit
                if (x_reg[MANT_W-1])
                begin
                    cnt_next   = '0;
                    frac_next  = '0;
                    state_next = E_SQUARE;
                end
                else
                begin
                    x_next = {x_reg[MANT_W-2:0], 1'b0};
                    k_next = k_reg - PREC_W'(1);
                end
            end
            E_SQUARE:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(x_reg);
                if (sq[MANT_W])
                begin
                    x_next    = sq[MANT_W:1];
                    frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    x_next    = sq[MANT_W-1:0];
                    frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b0};
                end
                if (cnt_reg == FRAC_CW'(LOG_FRAC_BITS - 1))
                begin
                    state_next = E_DIFF;
                end
                else
                begin
                    cnt_next = cnt_reg + FRAC_CW'(1);
                end
            end
            E_DIFF:
            begin
                l_next     = (lg > pf) ? '0 : pf - lg;
                state_next = E_SCALE;
            end
            E_SCALE:
            begin
                mul_a      = MUL_W'(l_reg);
                mul_b      = MUL_W'(LN2F);
                lnv_next   = product[LOG_FRAC_BITS +: LG_W];
                state_next = E_SHIFT;
            end
            E_SHIFT:
            begin
                est_next   = (scaled > 64'((1 << EST_W) - 1)) ? '1 : scaled[EST_W-1:0];
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign stat.done     = done_reg;
    assign stat.estimate = est_reg;

endmodule

`default_nettype wire

FILE: rtl/linear_counting_sketch_unit.sv
// Top level of the linear counting distinct-count sketch.
// Depends on lcs_pkg, lcs_ram, lcs_est_unit and the assertion macro header.
//
//   channel  | handshake              | word
//   ---------+------------------------+---------------------------------------------
//   cmd      | cmd_valid / cmd_ready  | cmd_word: opcode, hash_value
//   res      | res_valid / res_ready  | res_word: estimate, saturated, unset_bits,
//            |                        |           threshold
//   cfg      | cfg_we (no wait)       | cfg_wdata: precision
//
// An add reads the row of the bitmap RAM as the word is accepted and writes
// it back with the new bit in the next cycle, if that bit was not yet set.
// An estimate runs s = 18 - floor(log2 u) one-bit normalise shifts (0 to 18),
// then LOG_FRAC_BITS squarings and one ln 2 scaling on the shared multiplier,
// before the result register is loaded; with no unset bits left it skips the
// sequencer and loads a saturated all-ones estimate.
// After reset and after every precision write the bitmap RAM is swept clear,
// one row a cycle over all 2^(MAX_PRECISION-3) rows (32768 by default);
// cmd_ready stays low meanwhile. A result waiting in the output register
// holds back the next estimate and the commands behind it; earlier adds go on.
`default_nettype none

`include "linear_counting_sketch_unit_assert.svh"

module linear_counting_sketch_unit #(
    parameter int MAX_PRECISION = 18
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  lcs_pkg::cmd_word_t          cmd_word,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lcs_pkg::res_word_t          res_word,
    input  logic                        cfg_we,
    input  logic [lcs_pkg::PREC_W-1:0]  cfg_wdata
);

    import lcs_pkg::*;

    localparam int ROW_AW = MAX_PRECISION - ROW_LOG;
    localparam int DEPTH  = 1 << ROW_AW;
    localparam logic [PREC_W-1:0] PREC_MAX_V = PREC_W'(MAX_PRECISION);
    localparam logic [PREC_W-1:0] PREC_MIN_V = PREC_W'(PREC_MIN);
    localparam logic [PREC_W-1:0] PREC_RST_V =
        PREC_W'((PREC_RESET > MAX_PRECISION) ? MAX_PRECISION : PREC_RESET);

    lcs_state_t          state_reg, state_next;
    logic [ROW_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [PREC_W-1:0]   precision_reg, precision_next;
    logic [UNSET_W-1:0]  zero_count_reg, zero_count_next;
    logic [ROW_AW-1:0]   row_reg, row_next;
    logic [ROW_LOG-1:0]  bit_sel_reg, bit_sel_next;
    logic                out_valid_reg, out_valid_next;
    res_word_t           out_word_reg, out_word_next;

    logic                ram_we, ram_re;
    logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
    logic [ROW_W-1:0]    ram_wdata, ram_rdata, bit_mask;

    logic [PREC_W-1:0]        cfg_prec;
    logic [PREC_W-1:0]        idx_shift;
    logic [MAX_PRECISION-1:0] hash_idx;
    logic                     cmd_accept;

    est_ctrl_t est_ctrl;
    est_stat_t est_stat;

    // clamp a written precision into the supported range
    always_comb
    begin
        priority if (cfg_wdata < PREC_MIN_V)
        begin
            cfg_prec = PREC_MIN_V;
        end
        else if (cfg_wdata > PREC_MAX_V)
        begin
            cfg_prec = PREC_MAX_V;
        end
        else
        begin
            cfg_prec = cfg_wdata;
        end
    end

    // bitmap index: the top precision bits of the hash
    assign idx_shift  = PREC_MAX_V - precision_reg;
    assign hash_idx   = cmd_word.hash_value[HASH_W-1 -: MAX_PRECISION] >> idx_shift;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign cmd_accept = cmd_valid && cmd_ready;
    assign bit_mask   = ROW_W'(1) << bit_sel_reg;

    assign est_ctrl.start     = cmd_accept && (cmd_word.opcode == OP_ESTIMATE)
                                && (zero_count_reg != '0);
    assign est_ctrl.unset     = zero_count_reg;
    assign est_ctrl.precision = precision_reg;

    lcs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lcs_est_unit u_est (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (est_ctrl),
        .stat  (est_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            precision_reg  <= PREC_RST_V;
            zero_count_reg <= UNSET_W'(1) << PREC_RST_V;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            precision_reg  <= precision_next;
            zero_count_reg <= zero_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        bit_sel_reg  <= bit_sel_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        precision_next  = precision_reg;
        zero_count_next = zero_count_reg;
        row_next        = row_reg;
        bit_sel_next    = bit_sel_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        ram_we          = 1'b0;
        ram_waddr       = row_reg;
        ram_wdata       = ram_rdata | bit_mask;
        ram_re          = 1'b0;
        ram_raddr       = hash_idx[MAX_PRECISION-1:ROW_LOG];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep the bitmap to zero, one row a cycle
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ROW_AW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (cmd_word.opcode == OP_ADD)
                    begin
                        // fetch the row now, write it back next cycle
                        ram_re       = 1'b1;
                        row_next     = hash_idx[MAX_PRECISION-1:ROW_LOG];
                        bit_sel_next = hash_idx[ROW_LOG-1:0];
                        state_next   = ST_ADD;
                    end
                    else if (zero_count_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_EST;
                    end
                end
            end
            ST_ADD:
            begin
                // a bit already set leaves the count alone
                if ((ram_rdata & bit_mask) == '0)
                begin
                    ram_we = 1'b1;
                    if (zero_count_reg != '0)
                    begin
                        zero_count_next = zero_count_reg - UNSET_W'(1);
                    end
                end
                state_next = ST_IDLE;
            end
            ST_EST:
            begin
                if (est_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.saturated  = (zero_count_reg == '0);
                    out_word_next.estimate   = (zero_count_reg == '0) ? '1
                                               : est_stat.estimate;
                    out_word_next.unset_bits = zero_count_reg;
                    out_word_next.threshold  = threshold_of(precision_reg);
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a precision write restarts the sketch from empty
        if (cfg_we)
        begin
            precision_next  = cfg_prec;
            zero_count_next = UNSET_W'(1) << cfg_prec;
            clr_addr_next   = '0;
            state_next      = ST_CLEAR;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    // the count of zero bits never exceeds the bitmap size
    `LCS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        zero_count_reg <= (UNSET_W'(1) << precision_reg))

    // a write-back drops the count by at most one
    `LCS_ASSERT_NEXT(a_add_step, clk, rst_n, (state_reg == ST_ADD) && !cfg_we,
        (zero_count_reg == $past(zero_count_reg))
        || (zero_count_reg == $past(zero_count_reg) - UNSET_W'(1)))

    // the log sequencer is never started on an empty remainder
    `LCS_ASSERT_NOW(a_start_nonzero, clk, rst_n, est_ctrl.start,
        zero_count_reg != '0)

    // a saturated result carries an all-ones estimate
    `LCS_ASSERT_NOW(a_sat_ones, clk, rst_n, res_valid && res_word.saturated,
        res_word.estimate == '1)

endmodule

`default_nettype wire
